[sv/pcmcv_pkg.sv]
// Shared constants for the PCM int16 / float32 sample converter.
// No dependencies.
package pcmcv_pkg;

    // Conversion direction codes
    localparam logic DIR_I2F = 1'b0;
    localparam logic DIR_F2I = 1'b1;

    // Scale factor for float to int16 and IEEE-754 single layout
    localparam logic [14:0] SCALE_F2I = 15'd32767;
    localparam logic [7:0]  EXP_MAX   = 8'hFF;
    localparam logic [7:0]  EXP_I2F   = 8'd112;   // bias 127 minus 15
    localparam logic [9:0]  SHIFT_OFS = 10'd149;  // 150 minus one rounding bit

    // Right-shift window for the integer rounding step
    localparam logic [9:0]  K_SAT     = 10'd6;
    localparam logic [9:0]  K_ZERO    = 10'd26;

    localparam logic [15:0] POS_LIMIT = 16'd32767;
    localparam logic [16:0] NEG_LIMIT = 17'd32768;

endpackage

[sv/pcm_int16_float32_converter_unit.sv]
// Top level of the PCM int16 / float32 sample converter: a four-stage pipeline.
// Depends on pcmcv_pkg.
//
// Converts one sample per cycle while not stalled, an accepted word passing
// via r1-r3 to the output register. With direction 0 the low 16 bits are read
// as int16 and turned into the float32 value s/32768. With direction 1 the word is
// read as float32, scaled by 32767, rounded to single precision, saturated to
// int16 range and rounded half away from zero; NaN gives 0. The stages are decode
// and the 24x15 multiply, rounding to single precision, the alignment shift, and
// the final round, clamp and negate. The whole pipeline advances together and
// holds while the output word waits to be taken. The last mark travels with its
// sample. Write i_cfg_we only while the pipeline is empty.
module pcm_int16_float32_converter_unit
    import pcmcv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_sample_in,
    input  logic        i_last_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_sample_out,
    output logic        o_last_out
);

    logic r_dir;
    logic en;

    // pipeline advances unless the output word is stalled
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // ---------------- stage 1: decode, multiply, int16 to float ----------------
    logic        n1_sign;
    logic [7:0]  n1_exp;
    logic [23:0] n1_man;
    logic        n1_nan, n1_sat, n1_zero;
    logic [38:0] n1_prod;
    logic [31:0] n1_ibits;
    logic [15:0] n1_imag;
    logic [3:0]  n1_msb;
    logic [15:0] n1_norm;

    always_comb begin
        n1_sign = i_sample_in[31];
        n1_exp  = i_sample_in[30:23];
        n1_man  = {1'b1, i_sample_in[22:0]};
        n1_nan  = (n1_exp == EXP_MAX) && (i_sample_in[22:0] != 23'd0);
        n1_sat  = (n1_exp == EXP_MAX);
        n1_zero = (n1_exp == 8'd0);   // zero and subnormals round to 0
        n1_prod = 39'(n1_man) * 39'(SCALE_F2I);

        // int16 magnitude and leading one
        n1_imag = i_sample_in[15] ? 16'(-i_sample_in[15:0]) : i_sample_in[15:0];
        n1_msb  = 4'd0;
        for (int b = 0; b < 16; b++) begin
            if (n1_imag[b]) n1_msb = 4'(b);
        end
        n1_norm = n1_imag << (4'd15 - n1_msb);
        if (n1_imag == 16'd0) begin
            n1_ibits = 32'd0;
        end else begin
            n1_ibits = {i_sample_in[15], EXP_I2F + {4'd0, n1_msb}, n1_norm[14:0], 8'd0};
        end
    end

    logic        r1_v, r1_dir, r1_last, r1_sign, r1_nan, r1_sat, r1_zero;
    logic [7:0]  r1_exp;
    logic [38:0] r1_prod;
    logic [31:0] r1_ibits;

    // ---------------- stage 2: round product to single precision ----------------
    logic        n2_hi, n2_guard, n2_sticky, n2_rnd;
    logic [23:0] n2_keep;
    logic [24:0] n2_mr;
    logic [9:0]  n2_k;

    always_comb begin
        n2_hi = r1_prod[38];
        if (n2_hi) begin
            n2_keep   = r1_prod[38:15];
            n2_guard  = r1_prod[14];
            n2_sticky = |r1_prod[13:0];
        end else begin
            n2_keep   = r1_prod[37:14];
            n2_guard  = r1_prod[13];
            n2_sticky = |r1_prod[12:0];
        end
        n2_rnd = n2_guard && (n2_sticky || n2_keep[0]);
        n2_mr  = {1'b0, n2_keep} + {24'd0, n2_rnd};
        // right shift that leaves one fraction bit for the final round
        n2_k   = SHIFT_OFS - {2'd0, r1_exp} - (n2_hi ? 10'd15 : 10'd14);
    end

    logic        r2_v, r2_dir, r2_last, r2_sign, r2_nan, r2_sat, r2_zero;
    logic [24:0] r2_mr;
    logic [9:0]  r2_k;
    logic [31:0] r2_ibits;

    // ---------------- stage 3: align to one fraction bit ----------------
    logic        n3_sat, n3_zero;
    logic [18:0] n3_t;
    logic [24:0] n3_sh;

    always_comb begin
        // k as signed: large values mean tiny magnitudes
        n3_sat  = !r2_nan && (r2_sat || ($signed(r2_k) <= $signed(K_SAT)));
        n3_zero = r2_nan || r2_zero || (!n3_sat && ($signed(r2_k) >= $signed(K_ZERO)));
        n3_sh   = r2_mr >> r2_k[4:0];
        n3_t    = n3_sh[18:0];
    end

    logic        r3_v, r3_dir, r3_last, r3_sign, r3_sat, r3_zero;
    logic [18:0] r3_t;
    logic [31:0] r3_ibits;

    // ---------------- stage 4: round half away, clamp, negate ----------------
    logic [19:0] n4_sum;
    logic [18:0] n4_r;
    logic [15:0] n4_q;
    logic [31:0] n4_out;

    always_comb begin
        n4_sum = {1'b0, r3_t} + 20'd1;
        n4_r   = n4_sum[19:1];
        if (r3_zero) begin
            n4_q = 16'd0;
        end else if (!r3_sign) begin
            n4_q = (r3_sat || (n4_r > {3'd0, POS_LIMIT})) ? POS_LIMIT : n4_r[15:0];
        end else if (r3_sat || (n4_r > {2'd0, NEG_LIMIT})) begin
            n4_q = 16'h8000;
        end else begin
            n4_q = 16'(-n4_r[15:0]);
        end
        n4_out = (r3_dir == DIR_I2F) ? r3_ibits : {16'd0, n4_q};
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir       <= DIR_I2F;
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_dir <= i_cfg_wdata;
            if (en) begin
                r1_v        <= i_in_valid;
                r2_v        <= r1_v;
                r3_v        <= r2_v;
                o_out_valid <= r3_v;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dir   <= r_dir;
            r1_last  <= i_last_in;
            r1_sign  <= n1_sign;
            r1_nan   <= n1_nan;
            r1_sat   <= n1_sat;
            r1_zero  <= n1_zero;
            r1_exp   <= n1_exp;
            r1_prod  <= n1_prod;
            r1_ibits <= n1_ibits;

            r2_dir   <= r1_dir;
            r2_last  <= r1_last;
            r2_sign  <= r1_sign;
            r2_nan   <= r1_nan;
            r2_sat   <= r1_sat;
            r2_zero  <= r1_zero;
            r2_mr    <= n2_mr;
            r2_k     <= n2_k;
            r2_ibits <= r1_ibits;

            r3_dir   <= r2_dir;
            r3_last  <= r2_last;
            r3_sign  <= r2_sign;
            r3_sat   <= n3_sat;
            r3_zero  <= n3_zero;
            r3_t     <= n3_t;
            r3_ibits <= r2_ibits;

            o_sample_out <= n4_out;
            o_last_out   <= r3_last;
        end
    end

endmodule

[dv/pcm_int16_float32_converter_unit_test.sv]
// Testbench for the PCM int16 / float32 sample converter: directed and random words in
// both directions, with random idling, back-pressure and bit-exact prediction of results.
// Depends on pcmcv_pkg and pcm_int16_float32_converter_unit.
module pcm_int16_float32_converter_unit_test;
    import pcmcv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] sample;
        logic        last;
    } conv_word_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_sample_in = '0;
    logic        i_last_in = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_sample_out;
    logic        o_last_out;

    conv_word_t  pending_results[$];
    logic        dir_shadow = DIR_I2F;
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;

    pcm_int16_float32_converter_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .i_last_in    (i_last_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .o_last_out   (o_last_out)
    );

    always #1 i_clk = ~i_clk;

    // int16 in the low half times 2^-15, as float32 bits (always exact)
    function automatic logic [31:0] pcm_to_float_bits(logic [31:0] raw);
        logic [15:0] w;
        logic        sgn;
        logic [16:0] mag;
        logic [39:0] t;
        int          p;
        w = raw[15:0];
        sgn = w[15];
        mag = sgn ? (17'h10000 - {1'b0, w}) : {1'b0, w};
        if (mag == 0) return 32'h0;
        p = 16;
        while (!mag[p]) p--;
        t = 40'(mag) << (23 - p);
        return {sgn, 8'(p + 112), t[22:0]};
    endfunction

    // float32 bits times 32767, rounded to single, clamped, rounded half away from zero
    function automatic logic [15:0] float_bits_to_pcm(logic [31:0] raw);
        logic        sgn;
        logic [7:0]  e;
        logic [23:0] m;
        logic [63:0] prod, keep, rem, half, lim, q;
        logic [15:0] sat;
        int          ex, sh, n, s;
        sgn = raw[31];
        e = raw[30:23];
        sat = sgn ? 16'h8000 : 16'h7FFF;
        if (e == EXP_MAX) return (raw[22:0] != 0) ? 16'h0 : sat;
        m = (e == 0) ? {1'b0, raw[22:0]} : {1'b1, raw[22:0]};
        ex = (e == 0) ? -149 : int'(e) - 150;
        prod = 64'(m) * 64'(SCALE_F2I);
        if (prod == 0) return 16'h0;
        lim = sgn ? 64'(NEG_LIMIT) : 64'(POS_LIMIT);
        if (ex >= 0) return sat;
        sh = -ex;
        if (sh < 40 && prod > (lim << sh)) return sat;
        // round the exact product to 24 significant bits, ties to even
        n = 64;
        while (!prod[n-1]) n--;
        if (n > 24) begin
            s = n - 24;
            keep = prod >> s;
            rem = prod & ((64'd1 << s) - 1);
            half = 64'd1 << (s - 1);
            if (rem > half || (rem == half && keep[0])) keep++;
            prod = keep << s;
        end
        if (sh >= 62) q = 0;
        else q = (prod + (64'd1 << (sh - 1))) >> sh;
        return sgn ? 16'(-q) : 16'(q);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Watch both handshakes and the config port; predict on input, check on output
    always @(posedge i_clk) begin
        conv_word_t exp_word;
        if (i_rst_n) begin
            if (i_cfg_we) dir_shadow <= i_cfg_wdata;
            if (i_in_valid && o_in_ready) begin
                exp_word.last = i_last_in;
                exp_word.sample = (dir_shadow == DIR_I2F) ? pcm_to_float_bits(i_sample_in)
                                  : {16'h0, float_bits_to_pcm(i_sample_in)};
                pending_results.push_back(exp_word);
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected word", o_sample_out, 32'h0);
                end else begin
                    exp_word = pending_results.pop_front();
                    if (o_sample_out !== exp_word.sample)
                        report_mismatch("sample", o_sample_out, exp_word.sample);
                    if (o_last_out !== exp_word.last)
                        report_mismatch("last", {31'h0, o_last_out}, {31'h0, exp_word.last});
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one word; returns at the edge where it was taken
    task automatic send_word(input logic [31:0] sample, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_in <= sample;
        i_last_in <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_direction(input logic dir);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= dir;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_float();
        logic [31:0] r;
        r = $urandom;
        if ($urandom_range(2) != 0) r[30:23] = 8'($urandom_range(100, 130));
        return r;
    endfunction

    task automatic test_int_to_float_directed();
        logic [31:0] vals[8];
        vals = '{32'h0, 32'h1, 32'hFFFF, 32'h7FFF, 32'h8000, 32'hABCD8000,
                 32'hFFFF0001, 32'h00014000};
        set_direction(DIR_I2F);
        foreach (vals[i]) send_word(vals[i], i[0]);
    endtask

    task automatic test_float_to_int_directed();
        logic [31:0] vals[16];
        vals = '{32'h00000000, 32'h80000000, 32'h3F800000, 32'hBF800000,
                 32'h7F800000, 32'hFF800000, 32'h7FC00000, 32'hFFFFFFFF,
                 32'h7F7FFFFF, 32'h00000001, 32'h3F000000, 32'h3F800001,
                 32'hBF800001, 32'h3F7FFFFF, 32'hBF800080, 32'h38000100};
        set_direction(DIR_F2I);
        foreach (vals[i]) send_word(vals[i], i[0]);
    endtask

    task automatic test_random_mixed(input int count);
        for (int k = 0; k < count; k++) begin
            if (k % 50 == 0) set_direction(1'($urandom_range(1)));
            send_word(dir_shadow == DIR_I2F ? $urandom : random_float(),
                      1'($urandom_range(1)));
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        for (int k = 0; k < 40; k++) send_word(random_float(), 1'($urandom_range(1)));
        // sender pauses until everything has come out
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        for (int k = 0; k < 20; k++) send_word(random_float(), 1'($urandom_range(1)));
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_int_to_float_directed();
        test_float_to_int_directed();
        send_idle_pct = 29;
        recv_stall_pct = 70;
        test_random_mixed(270);
        send_idle_pct = 70;
        recv_stall_pct = 29;
        test_random_mixed(270);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_mixed(260);
        test_backpressure();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("pcm_int16_float32_converter_unit_test passed");
        end else begin
            $display("pcm_int16_float32_converter_unit_test failed");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("pcm_int16_float32_converter_unit_test failed");
        $finish;
    end

endmodule
